// ===== hdl/rhtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhtt_pkg: shared types for the rectangle hit-test table
// Request and result codes, the stored entry and the token passed cell to cell.
// ----------------------------------------------------------------------------
package rhtt_pkg;

	localparam int ENTRIES_DEF = 16;

	// config register indexes
	localparam logic CFG_OFS_X = 1'b0;
	localparam logic CFG_OFS_Y = 1'b1;

	typedef enum logic [1:0] {
		K_ADD    = 2'd0,
		K_REMOVE = 2'd1,
		K_UPDATE = 2'd2,
		K_TEST   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DUP     = 3'd1,
		ST_FULL    = 3'd2,
		ST_MISSING = 3'd3,
		ST_NOHIT   = 3'd4
	} status_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] x;
		logic [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
	} ent_t;

	typedef struct packed {
		logic        active;
		kind_t       kind;
		logic [15:0] id;
		logic [16:0] px;
		logic [16:0] py;
		logic [14:0] w;
		logic [14:0] h;
		logic        found;
		logic        done;
		logic [15:0] hit_id;
		logic [14:0] rel_x;
		logic [14:0] rel_y;
	} tok_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] hit_id;
		logic [14:0] rel_x;
		logic [14:0] rel_y;
	} rsp_t;

endpackage

// ===== hdl/rhtt_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhtt_req_if: request channel
// Valid/ready channel carrying one table request per beat.
// ----------------------------------------------------------------------------
interface rhtt_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [15:0]        zone_id;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [14:0]        width;
	logic [14:0]        height;

	modport source (output valid, kind, zone_id, pos_x, pos_y, width, height, input ready);
	modport sink   (input valid, kind, zone_id, pos_x, pos_y, width, height, output ready);
endinterface

// ===== hdl/rhtt_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhtt_rsp_if: result channel
// Valid/ready channel carrying one request result per beat.
// ----------------------------------------------------------------------------
interface rhtt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] hit_id;
	logic [14:0] rel_x;
	logic [14:0] rel_y;

	modport source (output valid, status, hit_id, rel_x, rel_y, input ready);
	modport sink   (input valid, status, hit_id, rel_x, rel_y, output ready);
endinterface

// ===== hdl/rhtt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhtt_cell: one table slot
// Holds one rectangle, checks the passing token against it and forwards the
// token to the next cell; on a remove the left neighbor takes this entry.
// ----------------------------------------------------------------------------
module rhtt_cell
	import rhtt_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  tok_t             tok_in,
	output tok_t             tok_out,
	input  ent_t             right_ent,
	input  logic             pull_in,
	output logic             pull_out,
	output ent_t             ent
);

	ent_t        ent_q;
	tok_t        tok_q;
	tok_t        tok_nx;
	logic        valid;
	logic        id_match;
	logic        wr;
	logic [17:0] dx;
	logic [17:0] dy;
	logic        in_x;
	logic        in_y;

	assign valid    = count > CNT_W'(IDX);
	assign id_match = valid && (ent_q.id == tok_in.id);
	assign dx       = {tok_in.px[16], tok_in.px} - {{2{ent_q.x[15]}}, ent_q.x};
	assign dy       = {tok_in.py[16], tok_in.py} - {{2{ent_q.y[15]}}, ent_q.y};
	assign in_x     = !dx[17] && (dx[16:0] < {2'b00, ent_q.w});
	assign in_y     = !dy[17] && (dy[16:0] < {2'b00, ent_q.h});
	assign pull_out = tok_in.active && (tok_in.kind == K_REMOVE) && tok_in.found;

	always_comb begin
		tok_nx = tok_in;
		wr     = 1'b0;
		if (tok_in.active && !tok_in.found) begin
			case (tok_in.kind)
				K_ADD: begin
					if (id_match) begin
						tok_nx.found = 1'b1;
					end else if (!tok_in.done && (count == CNT_W'(IDX))) begin
						wr          = 1'b1;
						tok_nx.done = 1'b1;
					end
				end
				K_REMOVE: begin
					if (id_match) begin
						tok_nx.found = 1'b1;
					end
				end
				K_UPDATE: begin
					if (id_match) begin
						tok_nx.found = 1'b1;
						wr           = 1'b1;
					end
				end
				default: begin
					if (valid && in_x && in_y) begin
						tok_nx.found  = 1'b1;
						tok_nx.hit_id = ent_q.id;
						tok_nx.rel_x  = dx[14:0];
						tok_nx.rel_y  = dy[14:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q.id <= tok_in.id;
			ent_q.x  <= tok_in.px[15:0];
			ent_q.y  <= tok_in.py[15:0];
			ent_q.w  <= tok_in.w;
			ent_q.h  <= tok_in.h;
		end else if (pull_in) begin
			ent_q <= right_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	assign tok_out = tok_q;
	assign ent     = ent_q;

endmodule

// ===== hdl/rectangle_hit_test_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_hit_test_table: ordered rectangle table with point hit test
// Requests add, remove, update or test against up to ENTRIES rectangles kept
// in insertion order, one rectangle per cell of a chain.
//
//   channel  dir  handshake      beat
//   req      in   valid/ready    kind, zone_id, pos_x, pos_y, width, height
//   rsp      out  valid/ready    status, hit_id, rel_x, rel_y
//   cfg      in   cfg_we         cfg_index, cfg_data (x offset, y offset)
//
// A request walks the cell chain one cell per cycle; its result is registered
// on rsp or in the skid slot as it leaves the chain, and only once it has left is
// the next request taken, so there is one request in the chain at a time.
// A new request is taken as soon as the chain is empty and the skid slot is free,
// so one finished result may wait on rsp while the next request runs.
// Reset clears the entry count, the origin and all handshake state; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module rectangle_hit_test_table
	import rhtt_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	rhtt_req_if.sink    req,
	rhtt_rsp_if.source  rsp
);

	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [15:0]      ofs_x_q;
	logic [15:0]      ofs_y_q;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	tok_t             head_q;
	tok_t             head_nx;
	rsp_t             out_q;
	logic             out_valid_q;
	rsp_t             pend_q;
	logic             pend_valid_q;

	tok_t             tok   [ENTRIES+1];
	ent_t             ents  [ENTRIES+1];
	logic             pulls [ENTRIES+1];
	logic [ENTRIES:0] act;

	logic             in_acc;
	logic             out_free;
	tok_t             tail;
	rsp_t             res;
	kind_t            req_kind;

	assign req_kind  = kind_t'(req.kind);
	assign req.ready = !busy_q && !pend_valid_q;
	assign in_acc    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign tail      = tok[ENTRIES];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_x_q <= '0;
			ofs_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFS_X: ofs_x_q <= cfg_data;
				CFG_OFS_Y: ofs_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// token injection
	always_comb begin
		head_nx        = '0;
		head_nx.active = in_acc;
		head_nx.kind   = req_kind;
		head_nx.id     = req.zone_id;
		head_nx.w      = req.width;
		head_nx.h      = req.height;
		if (req_kind == K_TEST) begin
			head_nx.px = {req.pos_x[15], req.pos_x} - {ofs_x_q[15], ofs_x_q};
			head_nx.py = {req.pos_y[15], req.pos_y} - {ofs_y_q[15], ofs_y_q};
		end else begin
			head_nx.px = {req.pos_x[15], req.pos_x};
			head_nx.py = {req.pos_y[15], req.pos_y};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q <= head_nx;
		end
	end

	assign tok[0]         = head_q;
	assign ents[ENTRIES]  = '0;
	assign pulls[ENTRIES] = 1'b0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		rhtt_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.count     (count_q),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1]),
			.right_ent (ents[i+1]),
			.pull_in   (pulls[i+1]),
			.pull_out  (pulls[i]),
			.ent       (ents[i])
		);
	end

	for (genvar i = 0; i <= ENTRIES; i++) begin : g_act
		assign act[i] = tok[i].active;
	end

	// result from the token leaving the chain
	always_comb begin
		res.hit_id = '0;
		res.rel_x  = '0;
		res.rel_y  = '0;
		unique case (tail.kind)
			K_ADD:    res.status = tail.found ? ST_DUP : (tail.done ? ST_OK : ST_FULL);
			K_REMOVE: res.status = tail.found ? ST_OK : ST_MISSING;
			K_UPDATE: res.status = tail.found ? ST_OK : ST_MISSING;
			default: begin
				res.status = tail.found ? ST_OK : ST_NOHIT;
				res.hit_id = tail.hit_id;
				res.rel_x  = tail.rel_x;
				res.rel_y  = tail.rel_y;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end
			if (tail.active) begin
				busy_q <= 1'b0;
				if (tail.kind == K_ADD && !tail.found && tail.done) begin
					count_q <= count_q + CNT_W'(1);
				end else if (tail.kind == K_REMOVE && tail.found) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (out_free) begin
				out_valid_q <= tail.active || pend_valid_q;
				if (pend_valid_q) begin
					pend_valid_q <= 1'b0;
				end
			end else if (tail.active) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (tail.active) begin
				out_q <= res;
			end
		end else if (tail.active) begin
			pend_q <= res;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_q.status;
	assign rsp.hit_id = out_q.hit_id;
	assign rsp.rel_x  = out_q.rel_x;
	assign rsp.rel_y  = out_q.rel_y;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act))
		else $error("more than one token in the chain");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (act == '0))
		else $error("token in the chain while idle");

	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("skid slot full with output empty");

	a_exit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |-> !pend_valid_q)
		else $error("result leaves chain with skid slot full");

endmodule
